>>> hw/rtl/sdq_pkg.sv
package sdq_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int TIME_W     = 32;
    localparam int ENTRIES_W  = 5;
    localparam int ADDR_W     = 3;

    localparam logic [TIME_W-1:0] RESET_UPDATE_INTERVAL = 32'd3600;
    localparam logic [TIME_W-1:0] RESET_FLUSH_INTERVAL  = 32'd300;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        RES_DONE     = 3'd0,
        RES_INSERTED = 3'd1,
        RES_DUP      = 3'd2,
        RES_PAST     = 3'd3,
        RES_FULL     = 3'd4
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_POP    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    insert;
        logic    pop;
        logic    clear;
        logic    out_load;
        logic    res_due;
        result_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    past;
        logic    scan_more;
        logic    dup;
        logic    full;
        logic    pop_more;
        logic    upd_reached;
        logic    flush_reached;
    } dp_stat_t;

endpackage

>>> hw/rtl/sdq_datapath.sv
module sdq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sdq_pkg::dp_cmd_t                    cmd,
    output sdq_pkg::dp_stat_t                   stat,
    input  sdq_pkg::action_t                    in_action,
    input  logic [sdq_pkg::TIME_W-1:0]          in_time_value,
    input  logic [sdq_pkg::TIME_W-1:0]          in_now_time,
    input  logic [sdq_pkg::TIME_W-1:0]          update_interval,
    input  logic [sdq_pkg::TIME_W-1:0]          flush_interval,
    output logic                                out_due,
    output logic [2:0]                          out_status,
    output logic [sdq_pkg::ENTRIES_W-1:0]       out_entries
);

    sdq_pkg::action_t                   action_reg;
    logic [sdq_pkg::TIME_W-1:0]         tv_reg;
    logic [sdq_pkg::TIME_W-1:0]         now_reg;
    logic [sdq_pkg::TIME_W-1:0]         list_reg  [sdq_pkg::LIST_DEPTH];
    logic [sdq_pkg::TIME_W-1:0]         list_next [sdq_pkg::LIST_DEPTH];
    logic [sdq_pkg::CNT_W-1:0]          count_reg;
    logic [sdq_pkg::CNT_W-1:0]          count_next;
    logic [sdq_pkg::CNT_W-1:0]          idx_reg;
    logic                               out_due_reg;
    logic [2:0]                         out_status_reg;
    logic [sdq_pkg::ENTRIES_W-1:0]      out_entries_reg;
    logic [sdq_pkg::TIME_W-1:0]         cur;
    logic                               idx_in_list;
    logic [sdq_pkg::TIME_W-1:0]         elapsed;

    assign cur         = list_reg[idx_reg[sdq_pkg::IDX_W-1:0]];
    assign idx_in_list = idx_reg < count_reg;
    assign elapsed     = now_reg - tv_reg;

    assign stat.action        = action_reg;
    assign stat.past          = tv_reg <= now_reg;
    assign stat.scan_more     = idx_in_list && (cur < tv_reg);
    assign stat.dup           = idx_in_list && (cur == tv_reg);
    assign stat.full          = count_reg == sdq_pkg::CNT_W'(sdq_pkg::LIST_DEPTH);
    assign stat.pop_more      = (count_reg != '0) && (list_reg[0] <= now_reg);
    // a last send later than now never counts as elapsed
    assign stat.upd_reached   = (now_reg >= tv_reg) && (elapsed >= update_interval);
    assign stat.flush_reached = (now_reg >= tv_reg) && (elapsed >= flush_interval);

    always_comb begin
        list_next = list_reg;
        if (cmd.insert) begin
            for (int i = 0; i < sdq_pkg::LIST_DEPTH; i++) begin
                if (sdq_pkg::CNT_W'(i) == idx_reg) begin
                    list_next[i] = tv_reg;
                end
            end
            for (int i = 1; i < sdq_pkg::LIST_DEPTH; i++) begin
                if (sdq_pkg::CNT_W'(i) > idx_reg) begin
                    list_next[i] = list_reg[i-1];
                end
            end
        end else if (cmd.pop) begin
            // drop the head, move everything down one place
            for (int i = 0; i < sdq_pkg::LIST_DEPTH - 1; i++) begin
                list_next[i] = list_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.insert) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        list_reg <= list_next;
        if (cmd.load) begin
            action_reg <= in_action;
            tv_reg     <= in_time_value;
            now_reg    <= in_now_time;
            idx_reg    <= '0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_due_reg     <= cmd.res_due;
            out_status_reg  <= cmd.res_status;
            out_entries_reg <= sdq_pkg::ENTRIES_W'(count_reg);
        end
    end

    assign out_due     = out_due_reg;
    assign out_status  = out_status_reg;
    assign out_entries = out_entries_reg;

endmodule

>>> hw/rtl/sdq_ctrl.sv
module sdq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sdq_pkg::dp_stat_t  stat,
    output sdq_pkg::dp_cmd_t   cmd
);

    sdq_pkg::state_t   state_reg, state_next;
    logic              due_reg, due_next;
    sdq_pkg::result_t  code_reg, code_next;
    logic              popped_reg, popped_next;
    logic              m_tvalid_reg, m_tvalid_next;

    assign s_tready = state_reg == sdq_pkg::S_IDLE;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next     = state_reg;
        due_next       = due_reg;
        code_next      = code_reg;
        popped_next    = popped_reg;
        cmd            = '0;
        cmd.res_due    = due_reg;
        cmd.res_status = code_reg;

        unique case (state_reg)
            sdq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sdq_pkg::S_DECIDE;
                end
            end
            sdq_pkg::S_DECIDE: begin
                due_next    = 1'b0;
                code_next   = sdq_pkg::RES_DONE;
                popped_next = 1'b0;
                unique case (stat.action)
                    sdq_pkg::ACT_ADD: begin
                        if (stat.past) begin
                            code_next  = sdq_pkg::RES_PAST;
                            state_next = sdq_pkg::S_FINISH;
                        end else begin
                            state_next = sdq_pkg::S_SCAN;
                        end
                    end
                    sdq_pkg::ACT_UPDATE: begin
                        state_next = sdq_pkg::S_POP;
                    end
                    sdq_pkg::ACT_FLUSH: begin
                        // expired entries go only once the flush is due
                        if (stat.flush_reached) begin
                            state_next = sdq_pkg::S_POP;
                        end else begin
                            state_next = sdq_pkg::S_FINISH;
                        end
                    end
                    sdq_pkg::ACT_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = sdq_pkg::S_FINISH;
                    end
                endcase
            end
            sdq_pkg::S_SCAN: begin
                priority if (stat.scan_more) begin
                    cmd.scan_step = 1'b1;
                end else if (stat.dup) begin
                    code_next  = sdq_pkg::RES_DUP;
                    state_next = sdq_pkg::S_FINISH;
                end else if (stat.full) begin
                    code_next  = sdq_pkg::RES_FULL;
                    state_next = sdq_pkg::S_FINISH;
                end else begin
                    cmd.insert = 1'b1;
                    code_next  = sdq_pkg::RES_INSERTED;
                    state_next = sdq_pkg::S_FINISH;
                end
            end
            sdq_pkg::S_POP: begin
                if (stat.pop_more) begin
                    cmd.pop     = 1'b1;
                    popped_next = 1'b1;
                end else begin
                    due_next   = (stat.action == sdq_pkg::ACT_FLUSH) || popped_reg ||
                                 stat.upd_reached;
                    state_next = sdq_pkg::S_FINISH;
                end
            end
            sdq_pkg::S_FINISH: begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = sdq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sdq_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
            due_reg      <= 1'b0;
            code_reg     <= sdq_pkg::RES_DONE;
            popped_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            due_reg      <= due_next;
            code_reg     <= code_next;
            popped_reg   <= popped_next;
        end
    end

endmodule

>>> hw/rtl/sorted_deadline_queue.sv
// Sorted deadline queue: holds up to 16 future deadlines in ascending order.
// s_tuser selects the action (0 add, 1 update check, 2 flush check, 3 clear);
// every transfer in gives exactly one transfer out carrying due, status and
// the entry count after the action. Items are handled one at a time: a
// transfer is taken, decoded in the next cycle and then finished, which is
// all that clear, an add of a time already past and a flush check that is
// not yet due do. Any other add walks the list to its sorted position, one
// entry at a time, before it decides. An update check, or a flush check that
// is due, removes the expired deadlines from the head one by one before it
// finishes. A result held back by m_tready delays the finish of the next
// item. A new item is accepted while the previous result still waits on
// m_tready. The list needs no clearing pass after reset. update_interval
// sits at address 0x0 and flush_interval at 0x4; write them only while the
// block is idle.
module sorted_deadline_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // time_value[31:0], now_time[63:32]
    input  logic [1:0]                  s_tuser,   // action[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // due[0], status[3:1], entries[8:4], zero
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [sdq_pkg::TIME_W-1:0]      upd_int_reg;
    logic [sdq_pkg::TIME_W-1:0]      flush_int_reg;
    logic                            cfg_wr;
    sdq_pkg::dp_cmd_t                cmd;
    sdq_pkg::dp_stat_t               stat;
    logic                            out_due;
    logic [2:0]                      out_status;
    logic [sdq_pkg::ENTRIES_W-1:0]   out_entries;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? flush_int_reg : upd_int_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_int_reg   <= sdq_pkg::RESET_UPDATE_INTERVAL;
            flush_int_reg <= sdq_pkg::RESET_FLUSH_INTERVAL;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                flush_int_reg <= pwdata;
            end else begin
                upd_int_reg <= pwdata;
            end
        end
    end

    sdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (sdq_pkg::action_t'(s_tuser)),
        .in_time_value   (s_tdata[31:0]),
        .in_now_time     (s_tdata[63:32]),
        .update_interval (upd_int_reg),
        .flush_interval  (flush_int_reg),
        .out_due         (out_due),
        .out_status      (out_status),
        .out_entries     (out_entries)
    );

    assign m_tdata = {7'd0, out_entries, out_status, out_due};

endmodule
